### rtl/spfa_pkg.sv
// ----------------------------------------------------------------------------
// spfa_pkg
// shared constants of the shortest path unit
// ----------------------------------------------------------------------------
package spfa_pkg;

    localparam int NODES      = 256;
    localparam int NODE_BITS  = 8;
    localparam int MAX_DEGREE = 16;
    localparam int DEG_BITS   = 5;
    localparam int SLOT_BITS  = 4;
    localparam int DIST_BITS  = 32;
    localparam int COST_BITS  = 16;
    localparam int CNT_BITS   = 9;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NEG   = 2'd3;

    localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

endpackage

### rtl/spfa_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// spfa_shortest_path_unit
// queue-driven bellman-ford shortest path engine with a shared relax unit
// ----------------------------------------------------------------------------
// Clear walks the degree memory one node per cycle. Add edge passes S_ADD1
// and S_ADD2 (S_ADD1 only with a node out of range), read S_READ1 and S_READ2.
// A run first sweeps all 256 nodes to reset distances, marks and counts,
// then pops queued nodes (S_POP, S_POP2) and walks each node's edges through
// one add and compare unit (S_EDGE, S_EDGE2, S_REL) until the queue empties
// or a node is queued as often as the clamped node count; a negative cycle
// adds a sweep that clears the queue marks. A run from a node out of range
// answers without a sweep. After reset the block sweeps the 256 node entries
// before accepting its first transfer. One result leaves per input transfer.
module spfa_shortest_path_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action, from_node, to_node, cost, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // distance, reachable, status, pad
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLEAR, S_ADD1, S_ADD2, S_READ1, S_READ2,
        S_RINIT, S_POP, S_POP2, S_EDGE, S_EDGE2, S_REL, S_FLUSH, S_OUT
    } state_t;

    state_t state_reg;
    logic [8:0] node_count_reg;
    logic [spfa_pkg::CNT_BITS-1:0] sweep_reg;

    logic [spfa_pkg::NODE_BITS-1:0] a_reg, b_reg;
    logic signed [spfa_pkg::COST_BITS-1:0] cost_reg;
    logic [8:0] n_eff;

    // memories
    logic signed [spfa_pkg::DIST_BITS-1:0] dist_mem [spfa_pkg::NODES];
    logic [spfa_pkg::DEG_BITS-1:0] deg_mem [spfa_pkg::NODES];
    logic [spfa_pkg::CNT_BITS-1:0] cnt_mem [spfa_pkg::NODES];
    logic mark_mem [spfa_pkg::NODES];
    logic [spfa_pkg::NODE_BITS-1:0] queue_mem [spfa_pkg::NODES];
    logic [spfa_pkg::NODE_BITS-1:0] head_mem [spfa_pkg::NODES*spfa_pkg::MAX_DEGREE];
    logic signed [spfa_pkg::COST_BITS-1:0] wt_mem [spfa_pkg::NODES*spfa_pkg::MAX_DEGREE];

    logic [spfa_pkg::NODE_BITS-1:0] qhead_reg, qtail_reg;
    logic [8:0] qfill_reg;
    logic [spfa_pkg::NODE_BITS-1:0] v_reg, w_reg;
    logic [spfa_pkg::DEG_BITS-1:0] deg_reg, k_reg;
    logic signed [spfa_pkg::DIST_BITS-1:0] dv_reg, dw_reg, dnew_reg;
    logic mark_w_reg;
    logic [spfa_pkg::CNT_BITS-1:0] cnt_w_reg;
    logic signed [spfa_pkg::COST_BITS-1:0] wt_reg;

    logic signed [spfa_pkg::DIST_BITS-1:0] res_dist_reg;
    logic res_reach_reg;
    logic [1:0] res_status_reg;
    logic ovalid_reg;

    logic signed [spfa_pkg::DIST_BITS:0] sum;
    logic signed [spfa_pkg::DIST_BITS-1:0] sat;

    assign n_eff = (node_count_reg == 9'd0) ? 9'd1 :
                   (node_count_reg > 9'd256) ? 9'd256 : node_count_reg;
    assign sum = {dv_reg[spfa_pkg::DIST_BITS-1], dv_reg}
               + {{(spfa_pkg::DIST_BITS+1-spfa_pkg::COST_BITS){wt_reg[spfa_pkg::COST_BITS-1]}},
                  wt_reg};
    always_comb
    begin
        if (sum[spfa_pkg::DIST_BITS] != sum[spfa_pkg::DIST_BITS-1])
        begin
            sat = sum[spfa_pkg::DIST_BITS] ? spfa_pkg::DIST_MIN : spfa_pkg::DIST_MAX;
        end
        else
        begin
            sat = sum[spfa_pkg::DIST_BITS-1:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {5'd0, res_status_reg, res_reach_reg, res_dist_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT ||
            (state_reg == S_RINIT && !sweep_reg[8] && ({1'b0, a_reg} < n_eff)))
        begin
            dist_mem[sweep_reg[7:0]] <= spfa_pkg::DIST_MAX;
            cnt_mem[sweep_reg[7:0]]  <= '0;
            mark_mem[sweep_reg[7:0]] <= 1'b0;
        end
        if (state_reg == S_INIT || state_reg == S_CLEAR)
        begin
            deg_mem[sweep_reg[7:0]] <= '0;
        end
        if (state_reg == S_ADD2 && deg_reg < 5'(spfa_pkg::MAX_DEGREE))
        begin
            head_mem[{a_reg, deg_reg[3:0]}] <= b_reg;
            wt_mem[{a_reg, deg_reg[3:0]}]   <= cost_reg;
            deg_mem[a_reg] <= deg_reg + 5'd1;
        end
        if (state_reg == S_RINIT && sweep_reg == 9'd256)
        begin
            dist_mem[a_reg] <= '0;
            queue_mem[8'd0] <= a_reg;
            mark_mem[a_reg] <= 1'b1;
        end
        if (state_reg == S_POP2)
        begin
            mark_mem[v_reg] <= 1'b0;
        end
        if (state_reg == S_REL && w_reg < n_eff[7:0] | n_eff[8])
        begin
            if (dnew_reg < dw_reg)
            begin
                dist_mem[w_reg] <= dnew_reg;
                if (!mark_w_reg)
                begin
                    queue_mem[qtail_reg] <= w_reg;
                    mark_mem[w_reg] <= 1'b1;
                    cnt_mem[w_reg] <= cnt_w_reg + 9'd1;
                end
            end
        end
        if (state_reg == S_FLUSH)
        begin
            mark_mem[sweep_reg[7:0]] <= 1'b0;
        end
    end

    logic rel_in_range;
    assign rel_in_range = n_eff[8] || ({1'b0, w_reg} < n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            ovalid_reg <= 1'b0;
            qhead_reg <= '0;
            qtail_reg <= '0;
            qfill_reg <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 9'd1;
                    if (sweep_reg == 9'd255)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        a_reg    <= s_axis_tdata[9:2];
                        b_reg    <= s_axis_tdata[17:10];
                        cost_reg <= s_axis_tdata[33:18];
                        res_dist_reg <= '0;
                        res_reach_reg <= 1'b0;
                        res_status_reg <= spfa_pkg::ST_OK;
                        sweep_reg <= '0;
                        unique case (s_axis_tdata[1:0])
                            spfa_pkg::ACT_CLEAR: state_reg <= S_CLEAR;
                            spfa_pkg::ACT_ADD:   state_reg <= S_ADD1;
                            spfa_pkg::ACT_RUN:   state_reg <= S_RINIT;
                            default:             state_reg <= S_READ1;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 9'd1;
                    if (sweep_reg == 9'd255)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_ADD1:
                begin
                    deg_reg <= deg_mem[a_reg];
                    if ({1'b0, a_reg} >= n_eff || {1'b0, b_reg} >= n_eff)
                    begin
                        res_status_reg <= spfa_pkg::ST_RANGE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ADD2;
                    end
                end
                S_ADD2:
                begin
                    if (deg_reg >= 5'(spfa_pkg::MAX_DEGREE))
                    begin
                        res_status_reg <= spfa_pkg::ST_FULL;
                    end
                    state_reg <= S_OUT;
                end
                S_READ1:
                begin
                    dv_reg <= dist_mem[a_reg];
                    state_reg <= S_READ2;
                end
                S_READ2:
                begin
                    if ({1'b0, a_reg} >= n_eff)
                    begin
                        res_status_reg <= spfa_pkg::ST_RANGE;
                        res_dist_reg <= spfa_pkg::DIST_MAX;
                    end
                    else
                    begin
                        res_dist_reg <= dv_reg;
                        res_reach_reg <= (dv_reg != spfa_pkg::DIST_MAX);
                    end
                    state_reg <= S_OUT;
                end
                S_RINIT:
                begin
                    if ({1'b0, a_reg} >= n_eff)
                    begin
                        res_status_reg <= spfa_pkg::ST_RANGE;
                        state_reg <= S_OUT;
                    end
                    else if (sweep_reg == 9'd256)
                    begin
                        qhead_reg <= '0;
                        qtail_reg <= 8'd1;
                        qfill_reg <= 9'd1;
                        state_reg <= S_POP;
                        v_reg <= a_reg;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + 9'd1;
                    end
                end
                S_POP:
                begin
                    // v_reg takes the queue head popped here
                    if (qfill_reg == 9'd0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        v_reg <= queue_mem[qhead_reg];
                        qhead_reg <= qhead_reg + 8'd1;
                        qfill_reg <= qfill_reg - 9'd1;
                        state_reg <= S_POP2;
                    end
                end
                S_POP2:
                begin
                    deg_reg <= deg_mem[v_reg];
                    dv_reg  <= dist_mem[v_reg];
                    k_reg   <= '0;
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    if (k_reg >= deg_reg || k_reg >= 5'(spfa_pkg::MAX_DEGREE))
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        w_reg  <= head_mem[{v_reg, k_reg[3:0]}];
                        wt_reg <= wt_mem[{v_reg, k_reg[3:0]}];
                        state_reg <= S_EDGE2;
                    end
                end
                S_EDGE2:
                begin
                    dw_reg     <= dist_mem[w_reg];
                    mark_w_reg <= mark_mem[w_reg];
                    cnt_w_reg  <= cnt_mem[w_reg];
                    dnew_reg   <= sat;
                    state_reg  <= S_REL;
                end
                S_REL:
                begin
                    k_reg <= k_reg + 5'd1;
                    state_reg <= S_EDGE;
                    if (rel_in_range && dnew_reg < dw_reg)
                    begin
                        if (w_reg == v_reg)
                        begin
                            dv_reg <= dnew_reg;
                        end
                        if (!mark_w_reg)
                        begin
                            qtail_reg <= qtail_reg + 8'd1;
                            qfill_reg <= qfill_reg + 9'd1;
                            if (cnt_w_reg + 9'd1 >= n_eff)
                            begin
                                res_status_reg <= spfa_pkg::ST_NEG;
                                sweep_reg <= '0;
                                state_reg <= S_FLUSH;
                            end
                        end
                    end
                end
                S_FLUSH:
                begin
                    sweep_reg <= sweep_reg + 9'd1;
                    qhead_reg <= '0;
                    qtail_reg <= '0;
                    qfill_reg <= '0;
                    if (sweep_reg == 9'd255)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/spfa_checker.sv
// ----------------------------------------------------------------------------
// spfa_checker
// port-level checks of the shortest path unit
// ----------------------------------------------------------------------------
module spfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // no new input while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // an input transfer is never answered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result too early");

    // reachable only with a finite distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] != 32'h7fffffff))
        else $error("reachable with max distance");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");

endmodule

bind spfa_shortest_path_unit spfa_checker u_spfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the shortest path unit against a behavioral predictor: directed
// items cover range, full-list, stale-edge and negative-cycle cases, then
// random graphs are loaded, solved and read back under random flow control
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic signed [spfa_pkg::DIST_BITS-1:0] distance;
        logic                                  reach;
        logic [1:0]                            status;
    } path_answer_t;

    class path_scoreboard;
        int unsigned  node_count = 256;
        longint       node_dist[spfa_pkg::NODES];
        int unsigned  degree[spfa_pkg::NODES];
        int unsigned  edge_to[spfa_pkg::NODES*spfa_pkg::MAX_DEGREE];
        longint       edge_cost[spfa_pkg::NODES*spfa_pkg::MAX_DEGREE];
        path_answer_t pending[$];
        int           errors = 0;

        function new();
            foreach (node_dist[i]) node_dist[i] = spfa_pkg::DIST_MAX;
            foreach (degree[i]) degree[i] = 0;
        endfunction

        function int unsigned eff_n();
            if (node_count == 0) return 1;
            if (node_count > spfa_pkg::NODES) return spfa_pkg::NODES;
            return node_count;
        endfunction

        function longint sat_sum(longint a, longint c);
            longint s;
            s = a + c;
            if (s > longint'(spfa_pkg::DIST_MAX)) return spfa_pkg::DIST_MAX;
            if (s < longint'(spfa_pkg::DIST_MIN)) return spfa_pkg::DIST_MIN;
            return s;
        endfunction

        // true when a negative cycle stops the walk
        function bit solve_from(int unsigned src, int unsigned n);
            int unsigned fifo[spfa_pkg::NODES];
            bit          queued[spfa_pkg::NODES];
            int unsigned pushes[spfa_pkg::NODES];
            int unsigned head, tail, fill, v, w, slot;
            longint      d;
            head = 0; tail = 0; fill = 0;
            foreach (node_dist[i])
            begin
                node_dist[i] = spfa_pkg::DIST_MAX;
                queued[i] = 0;
                pushes[i] = 0;
            end
            node_dist[src] = 0;
            fifo[tail] = src; tail = (tail + 1) % spfa_pkg::NODES; fill++; queued[src] = 1;
            while (fill > 0)
            begin
                v = fifo[head]; head = (head + 1) % spfa_pkg::NODES; fill--; queued[v] = 0;
                for (int k = 0; k < degree[v]; k++)
                begin
                    slot = v * spfa_pkg::MAX_DEGREE + k;
                    w = edge_to[slot];
                    if (w >= n) continue;
                    d = sat_sum(node_dist[v], edge_cost[slot]);
                    if (d < node_dist[w])
                    begin
                        node_dist[w] = d;
                        if (!queued[w])
                        begin
                            fifo[tail] = w; tail = (tail + 1) % spfa_pkg::NODES; fill++;
                            queued[w] = 1;
                            pushes[w]++;
                            if (pushes[w] >= n) return 1;
                        end
                    end
                end
            end
            return 0;
        endfunction

        function void note_item(logic [1:0] act, int unsigned a, int unsigned b,
                                logic signed [spfa_pkg::COST_BITS-1:0] cost);
            path_answer_t r;
            int unsigned  n;
            n = eff_n();
            r.distance = 0; r.reach = 0; r.status = spfa_pkg::ST_OK;
            case (act)
                spfa_pkg::ACT_CLEAR: foreach (degree[i]) degree[i] = 0;
                spfa_pkg::ACT_ADD:
                    if (a >= n || b >= n) r.status = spfa_pkg::ST_RANGE;
                    else if (degree[a] >= spfa_pkg::MAX_DEGREE) r.status = spfa_pkg::ST_FULL;
                    else
                    begin
                        edge_to[a*spfa_pkg::MAX_DEGREE + degree[a]] = b;
                        edge_cost[a*spfa_pkg::MAX_DEGREE + degree[a]] = longint'(cost);
                        degree[a]++;
                    end
                spfa_pkg::ACT_RUN:
                    if (a >= n) r.status = spfa_pkg::ST_RANGE;
                    else if (solve_from(a, n)) r.status = spfa_pkg::ST_NEG;
                default:
                    if (a >= n)
                    begin
                        r.status = spfa_pkg::ST_RANGE;
                        r.distance = spfa_pkg::DIST_MAX;
                    end
                    else
                    begin
                        r.distance = 32'(node_dist[a]);
                        r.reach = (node_dist[a] < longint'(spfa_pkg::DIST_MAX));
                    end
            endcase
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [39:0] data);
            path_answer_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.distance)
                report($sformatf("distance %0d, expected %0d",
                                 $signed(data[31:0]), e.distance));
            if (data[32] !== e.reach)
                report($sformatf("reachable %b, expected %b", data[32], e.reach));
            if (data[34:33] !== e.status)
                report($sformatf("status %0d, expected %0d", data[34:33], e.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;

    path_scoreboard sb;
    int             items_sent = 0;
    int             cycles = 0;
    int             hold_cycles = 0;
    int             stall_cycles = 0;
    bit             no_gaps = 0;
    int unsigned    n_cur = 256;

    spfa_shortest_path_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 20000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 0;
            hold_cycles--;
        end
        else if (stall_cycles > 0)
        begin
            m_axis_tready <= 0;
            stall_cycles--;
        end
        else
            m_axis_tready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
            stall_cycles = no_gaps ? 0 : $urandom_range(0, 19);
        end
    end

    task send_item(logic [1:0] act, int unsigned a, int unsigned b,
                   logic signed [spfa_pkg::COST_BITS-1:0] cost);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {6'b0, cost, b[7:0], a[7:0], act};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(act, a, b, cost);
        items_sent++;
    endtask

    task drain();
        @(negedge clk);
        s_axis_tvalid = 0;
        while (sb.pending.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task write_node_count(logic [8:0] value);
        drain();
        cfg_we = 1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 0;
        sb.node_count = 32'(value);
        n_cur = sb.eff_n();
    endtask

    function int unsigned pick_node();
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, n_cur - 1);
    endfunction

    function logic signed [spfa_pkg::COST_BITS-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return -$signed(16'($urandom_range(0, 3)));
            default: return 16'($urandom_range(0, 50));
        endcase
    endfunction

    // one graph: clear, load, solve and read back a few times, then up to three random items
    task graph_phase();
        int unsigned edges;
        edges = $urandom_range(0, (n_cur > 16) ? 40 : 3 * n_cur + 2);
        send_item(spfa_pkg::ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                  16'($urandom));
        repeat (edges)
            send_item(spfa_pkg::ACT_ADD, pick_node(), pick_node(), pick_cost());
        repeat ($urandom_range(1, 3))
        begin
            send_item(spfa_pkg::ACT_RUN, pick_node(), $urandom_range(0, 255),
                      16'($urandom));
            repeat ($urandom_range(2, 8))
                send_item(spfa_pkg::ACT_READ, pick_node(), $urandom_range(0, 255),
                          16'($urandom));
        end
        repeat ($urandom_range(0, 3))
            send_item(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 255), 16'($urandom));
    endtask

    initial
    begin
        int unsigned counts[] = '{1, 0, 511, 256, 2, 3, 4};
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed part, first at the reset node count
        send_item(spfa_pkg::ACT_READ, 0, 0, 0);
        send_item(spfa_pkg::ACT_ADD, 0, 255, -16'sd32768);
        send_item(spfa_pkg::ACT_ADD, 255, 0, 16'sd32767);
        send_item(spfa_pkg::ACT_RUN, 0, 0, 0);
        send_item(spfa_pkg::ACT_READ, 255, 0, 0);
        send_item(spfa_pkg::ACT_READ, 0, 0, 0);
        send_item(spfa_pkg::ACT_READ, 7, 0, 0);
        for (int k = 0; k < 17; k++)
            send_item(spfa_pkg::ACT_ADD, 1, k, 1);
        send_item(spfa_pkg::ACT_CLEAR, 255, 255, -1);
        send_item(spfa_pkg::ACT_RUN, 255, 0, 0);
        write_node_count(4);
        send_item(spfa_pkg::ACT_ADD, 5, 1, 0);
        send_item(spfa_pkg::ACT_ADD, 1, 200, 0);
        send_item(spfa_pkg::ACT_READ, 200, 0, 0);
        send_item(spfa_pkg::ACT_RUN, 9, 0, 0);
        send_item(spfa_pkg::ACT_ADD, 0, 3, 5);
        send_item(spfa_pkg::ACT_ADD, 1, 2, -1);
        send_item(spfa_pkg::ACT_ADD, 2, 1, -1);
        send_item(spfa_pkg::ACT_RUN, 1, 0, 0);
        send_item(spfa_pkg::ACT_READ, 2, 0, 0);
        write_node_count(2);
        send_item(spfa_pkg::ACT_RUN, 0, 0, 0);
        send_item(spfa_pkg::ACT_READ, 1, 0, 0);

        // receiver holds off while items keep coming
        write_node_count(8);
        hold_cycles = 1500;
        no_gaps = 1;
        graph_phase();
        no_gaps = 0;

        while (items_sent < 950)
        begin
            if ($urandom_range(0, 3) == 0)
                write_node_count(9'(counts[$urandom_range(0, counts.size() - 1)]));
            else
                write_node_count(9'($urandom_range(2, 16)));
            no_gaps = ($urandom_range(0, 4) == 0);
            graph_phase();
        end
        no_gaps = 0;
        drain();
        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
rtl/spfa_pkg.sv
rtl/spfa_shortest_path_unit.sv
rtl/spfa_checker.sv
tb/testbench.sv
